@@ hw/rtl/ultrasonic_obstacle_interlock_macros.svh @@
// Assertion macros for the ultrasonic obstacle interlock.
// Used by the top level only; empty when SYNTHESIS is defined.
`ifndef ULTRASONIC_OBSTACLE_INTERLOCK_MACROS_SVH
`define ULTRASONIC_OBSTACLE_INTERLOCK_MACROS_SVH
`ifndef SYNTHESIS
`define UOI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("interlock assertion failed");
`define UOI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("interlock assertion failed");
`else
`define UOI_ASSERT_NOW(lbl, ante, cons)
`define UOI_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/uoi_pkg.sv @@
// Types and constants for the ultrasonic obstacle interlock.
// No dependencies; used by ultrasonic_obstacle_interlock.
package uoi_pkg;

    localparam int WIDTH_W = 15;
    localparam int DIST_W  = 16;
    localparam int CNT_W   = 4;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // (w*100+29)/58 == (w*50+14)/29, done as (w*50+14)*ceil(2^26/29) >> 26.
    // Exact for w*50+14 < 2^21.
    localparam int DIV_SHIFT = 26;
    localparam int PROD_W    = 43;
    localparam logic [26:0] DIV_MUL = 27'd115704950;  // 50 * 2314099
    localparam logic [24:0] DIV_ADD = 25'd32397386;   // 14 * 2314099

    localparam logic [2:0] REG_OBSTACLE_BELOW = 3'd0;
    localparam logic [2:0] REG_CLEAR_ABOVE    = 3'd1;
    localparam logic [2:0] REG_TRIGGER_COUNT  = 3'd2;
    localparam logic [2:0] REG_CLEAR_COUNT    = 3'd3;
    localparam logic [2:0] REG_MIN_VALID      = 3'd4;
    localparam logic [2:0] REG_MAX_VALID      = 3'd5;

    localparam logic [DIST_W-1:0] RST_OBSTACLE_BELOW = 16'd2000;
    localparam logic [DIST_W-1:0] RST_CLEAR_ABOVE    = 16'd2500;
    localparam logic [CNT_W-1:0]  RST_TRIGGER_COUNT  = 4'd2;
    localparam logic [CNT_W-1:0]  RST_CLEAR_COUNT    = 4'd3;
    localparam logic [DIST_W-1:0] RST_MIN_VALID      = 16'd300;
    localparam logic [DIST_W-1:0] RST_MAX_VALID      = 16'd30000;

    typedef struct packed {
        logic [CNT_W-1:0]  obstacle_run;
        logic              stop_request;
        logic              blocked;
        logic [DIST_W-1:0] range_hcm;
    } result_word_t;

endpackage

@@ hw/rtl/ultrasonic_obstacle_interlock.sv @@
// Ultrasonic obstacle interlock: echo width to distance, validity window,
// debounced hysteresis block/unblock. Depends on uoi_pkg and the macros header.
//
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    tdata echo_us, tuser timed_out
//  m_        out  m_tvalid/m_tready    tdata range/flags, tuser range_ok
//  apb       in   psel/penable/pready  six 32-bit registers at 4*i
//
// One word per cycle sustained while m_ is not stalled; an accepted word goes to the
// input register, then through one pass of multiply-by-reciprocal and counter logic
// into the result register, which offers it on m_. A stalled m_ side holds the
// result register and the input register still takes one more word. Synchronous
// active-low reset clears counters, blocked flag, valids and registers to defaults.
`include "ultrasonic_obstacle_interlock_macros.svh"

module ultrasonic_obstacle_interlock #(
    parameter int unsigned MAX_ECHO_US = 30000
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [14:0] echo_us, [15] zero fill
    input  logic        s_tuser,   // [0] timed_out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] range_hcm, [16] blocked,
                                   // [17] stop_request, [21:18] obstacle_run
    output logic        m_tuser,   // [0] range_ok
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DW = uoi_pkg::DIST_W;
    localparam int CW = uoi_pkg::CNT_W;

    logic [DW-1:0] obstacle_below_reg;
    logic [DW-1:0] clear_above_reg;
    logic [CW-1:0] trigger_count_reg;
    logic [CW-1:0] clear_count_reg;
    logic [DW-1:0] min_valid_reg;
    logic [DW-1:0] max_valid_reg;

    logic                        a_valid_reg;
    logic [uoi_pkg::WIDTH_W-1:0] a_width_reg;
    logic                        a_tout_reg;

    logic [CW-1:0] obs_cnt_reg, obs_cnt_next;
    logic [CW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          blocked_reg, blocked_next;

    logic                 m_valid_reg;
    uoi_pkg::result_word_t m_word_reg;
    logic                 m_dvalid_reg;

    logic                        adv;
    logic                        cfg_wr;
    logic                        tout;
    logic [uoi_pkg::PROD_W-1:0]  prod;
    logic [DW-1:0]               range_calc;
    logic                        dvalid;
    logic                        stop;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            obstacle_below_reg <= uoi_pkg::RST_OBSTACLE_BELOW;
            clear_above_reg    <= uoi_pkg::RST_CLEAR_ABOVE;
            trigger_count_reg  <= uoi_pkg::RST_TRIGGER_COUNT;
            clear_count_reg    <= uoi_pkg::RST_CLEAR_COUNT;
            min_valid_reg      <= uoi_pkg::RST_MIN_VALID;
            max_valid_reg      <= uoi_pkg::RST_MAX_VALID;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                uoi_pkg::REG_OBSTACLE_BELOW: obstacle_below_reg <= pwdata[DW-1:0];
                uoi_pkg::REG_CLEAR_ABOVE:    clear_above_reg    <= pwdata[DW-1:0];
                uoi_pkg::REG_TRIGGER_COUNT:  trigger_count_reg  <= pwdata[CW-1:0];
                uoi_pkg::REG_CLEAR_COUNT:    clear_count_reg    <= pwdata[CW-1:0];
                uoi_pkg::REG_MIN_VALID:      min_valid_reg      <= pwdata[DW-1:0];
                uoi_pkg::REG_MAX_VALID:      max_valid_reg      <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            uoi_pkg::REG_OBSTACLE_BELOW: prdata = 32'(obstacle_below_reg);
            uoi_pkg::REG_CLEAR_ABOVE:    prdata = 32'(clear_above_reg);
            uoi_pkg::REG_TRIGGER_COUNT:  prdata = 32'(trigger_count_reg);
            uoi_pkg::REG_CLEAR_COUNT:    prdata = 32'(clear_count_reg);
            uoi_pkg::REG_MIN_VALID:      prdata = 32'(min_valid_reg);
            uoi_pkg::REG_MAX_VALID:      prdata = 32'(max_valid_reg);
            default:                     prdata = '0;
        endcase
    end

    // Two-register pipe: input register feeds the result register.
    assign adv      = a_valid_reg & (~m_valid_reg | m_tready);
    assign s_tready = ~a_valid_reg | adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_tready) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            a_width_reg <= s_tdata[uoi_pkg::WIDTH_W-1:0];
            a_tout_reg  <= s_tuser;
        end
    end

    always_comb begin
        tout = a_tout_reg | ({1'b0, a_width_reg} >= 16'(MAX_ECHO_US));
        prod = uoi_pkg::PROD_W'(a_width_reg) * uoi_pkg::PROD_W'(uoi_pkg::DIV_MUL)
             + uoi_pkg::PROD_W'(uoi_pkg::DIV_ADD);
        range_calc = tout ? '0 : prod[uoi_pkg::DIV_SHIFT +: DW];
        dvalid     = ~tout & (range_calc >= min_valid_reg) & (range_calc <= max_valid_reg);

        obs_cnt_next = obs_cnt_reg;
        clr_cnt_next = clr_cnt_reg;
        blocked_next = blocked_reg;
        stop         = 1'b0;
        if (!dvalid) begin
            obs_cnt_next = '0;
            clr_cnt_next = '0;
        end else if (range_calc < obstacle_below_reg) begin
            clr_cnt_next = '0;
            if (obs_cnt_reg < trigger_count_reg) begin
                obs_cnt_next = obs_cnt_reg + 1'b1;
            end
            if (obs_cnt_next >= trigger_count_reg && !blocked_reg) begin
                blocked_next = 1'b1;
                stop         = 1'b1;
            end
        end else begin
            obs_cnt_next = '0;
            if (range_calc > clear_above_reg) begin
                if (clr_cnt_reg < clear_count_reg) begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
                if (clr_cnt_next >= clear_count_reg) begin
                    blocked_next = 1'b0;
                end
            end else begin
                clr_cnt_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            obs_cnt_reg <= '0;
            clr_cnt_reg <= '0;
            blocked_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                obs_cnt_reg <= obs_cnt_next;
                clr_cnt_reg <= clr_cnt_next;
                blocked_reg <= blocked_next;
            end
            if (adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_word_reg.range_hcm    <= range_calc;
            m_word_reg.blocked      <= blocked_next;
            m_word_reg.stop_request <= stop;
            m_word_reg.obstacle_run <= obs_cnt_next;
            m_dvalid_reg            <= dvalid;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = 24'(m_word_reg);
    assign m_tuser  = m_dvalid_reg;

    `UOI_ASSERT_NEXT(a_adv_loads, adv, m_tvalid)
    `UOI_ASSERT_NOW(a_block_stops, $rose(blocked_reg), m_tvalid && m_word_reg.stop_request)
    `UOI_ASSERT_NOW(a_invalid_clears, m_tvalid && !m_tuser, m_word_reg.obstacle_run == '0)

endmodule
